[rtl/stt_pkg.sv]
`timescale 1ns / 1ps
package stt_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned ID_W   = 8;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_BADID    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DIV,
      S_STEP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                start;
      logic [TIME_W-1:0]   dividend;
      logic [TIME_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [TIME_W-1:0]   rem;
   } div_rsp_type;

endpackage

[rtl/stt_rem_unit.sv]
`timescale 1ns / 1ps
// restoring remainder, one bit per cycle
module stt_rem_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  stt_pkg::div_req_type div_req,
   output stt_pkg::div_rsp_type div_rsp
);

   localparam int unsigned W  = stt_pkg::TIME_W;
   localparam int unsigned BW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [BW-1:0] bc_ff, bc_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      bc_in   = bc_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         bc_in   = '0;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = diff[W] ? trial[W-1:0] : diff[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         bc_in  = bc_ff + 1'b1;
         if (bc_ff == BW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bc_ff  <= bc_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

[rtl/software_timer_table_unit.sv]
`timescale 1ns / 1ps
// Software timer table. Request channel (req_*) carries one item with a
// mode: add, cancel, clear or tick. Response channel (rsp_*) returns items;
// add, cancel and clear give one item, a tick gives one per due timer in
// newest-to-oldest order (or one empty item), the final one with rsp_last.
// One item is handled at a time; req_ready is high only when idle.
// Add, clear, cancel of id zero and a walk of an empty table go straight
// to the finish state, which loads the final response. Cancel and tick
// walk the table by rotating it through the head slot: a scan and a step
// state per entry, with a run of the shared bit-serial remainder unit
// between them for each due entry with a nonzero period, then finish.
// A new item can be accepted in the cycle after the final response loads.
// The response sits in an output register; a stalled receiver holds the
// sequencer only when a further response item is ready to go out.
// Reset empties the table; entries carry no reset and are only read below
// the fill count.
module software_timer_table_unit #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_period,
   input  logic        req_repeats,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_fired_id,
   output logic        rsp_fired,
   output logic        rsp_last
);

   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned TW = stt_pkg::TIME_W;
   localparam int unsigned IW = stt_pkg::ID_W;

   stt_pkg::state_type  state_ff, state_in;
   stt_pkg::mode_type   mode_ff;
   stt_pkg::status_type status_ff;

   logic [IW-1:0] id_ff  [ENTRIES];
   logic [TW-1:0] per_ff [ENTRIES];
   logic [TW-1:0] lr_ff  [ENTRIES];
   logic          rep_ff [ENTRIES];

   logic [CW-1:0] cnt_ff, left_ff, tail;
   logic [IW-1:0] tid_ff, pend_id_ff;
   logic [TW-1:0] now_ff, newlr_ff;
   logic          pend_ff, found_ff, fire_ff, keep_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [IW-1:0] rsp_id_ff;
   logic          rsp_fired_ff, rsp_last_ff;

   logic          out_free, accept, step_go, emit_pend, emit_final;
   logic [TW-1:0] elapsed;
   logic          due;

   stt_pkg::div_req_type div_req;
   stt_pkg::div_rsp_type div_rsp;

   stt_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign elapsed  = now_ff - lr_ff[0];
   assign due      = (elapsed >= per_ff[0]);
   assign tail     = cnt_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stt_pkg::S_IDLE: begin
            if (accept) begin
               if ((req_mode == stt_pkg::MODE_CANCEL && req_task_id != '0 && cnt_ff != '0)
                   || (req_mode == stt_pkg::MODE_TICK && cnt_ff != '0)) begin
                  state_in = stt_pkg::S_SCAN;
               end else begin
                  state_in = stt_pkg::S_FINISH;
               end
            end
         end
         stt_pkg::S_SCAN: begin
            if (mode_ff == stt_pkg::MODE_TICK && due && per_ff[0] != '0) begin
               state_in = stt_pkg::S_DIV;
            end else begin
               state_in = stt_pkg::S_STEP;
            end
         end
         stt_pkg::S_DIV: begin
            if (div_rsp.done) begin
               state_in = stt_pkg::S_STEP;
            end
         end
         stt_pkg::S_STEP: begin
            if (step_go) begin
               state_in = (left_ff == CW'(1)) ? stt_pkg::S_FINISH : stt_pkg::S_SCAN;
            end
         end
         stt_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = stt_pkg::S_IDLE;
            end
         end
         default: state_in = stt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == stt_pkg::S_IDLE);
      accept           = req_ready && req_valid;
      step_go          = (state_ff == stt_pkg::S_STEP) && (!(fire_ff && pend_ff) || out_free);
      emit_pend        = step_go && fire_ff && pend_ff;
      emit_final       = (state_ff == stt_pkg::S_FINISH) && out_free;
      div_req.start    = (state_ff == stt_pkg::S_SCAN) && (state_in == stt_pkg::S_DIV);
      div_req.dividend = elapsed;
      div_req.divisor  = per_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stt_pkg::S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_pend || emit_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            pend_ff <= 1'b0;
            if (req_mode == stt_pkg::MODE_CLEAR) begin
               cnt_ff <= '0;
            end else if (req_mode == stt_pkg::MODE_ADD && req_task_id != '0
                         && cnt_ff != CW'(ENTRIES)) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (step_go) begin
            if (fire_ff) begin
               pend_ff <= 1'b1;
            end
            if (!keep_ff) begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end

      if (accept) begin
         mode_ff  <= stt_pkg::mode_type'(req_mode);
         tid_ff   <= req_task_id;
         now_ff   <= req_now;
         left_ff  <= cnt_ff;
         found_ff <= 1'b0;
         unique case (stt_pkg::mode_type'(req_mode))
            stt_pkg::MODE_ADD: begin
               if (req_task_id == '0) begin
                  status_ff <= stt_pkg::ST_BADID;
               end else if (cnt_ff == CW'(ENTRIES)) begin
                  status_ff <= stt_pkg::ST_FULL;
               end else begin
                  status_ff <= stt_pkg::ST_OK;
                  for (int i = ENTRIES - 1; i > 0; i--) begin
                     id_ff[i]  <= id_ff[i-1];
                     per_ff[i] <= per_ff[i-1];
                     lr_ff[i]  <= lr_ff[i-1];
                     rep_ff[i] <= rep_ff[i-1];
                  end
                  id_ff[0]  <= req_task_id;
                  per_ff[0] <= req_period;
                  lr_ff[0]  <= req_now;
                  rep_ff[0] <= req_repeats;
               end
            end
            stt_pkg::MODE_CANCEL: begin
               status_ff <= (req_task_id == '0) ? stt_pkg::ST_BADID : stt_pkg::ST_NOTFOUND;
            end
            stt_pkg::MODE_CLEAR: status_ff <= stt_pkg::ST_OK;
            stt_pkg::MODE_TICK:  status_ff <= stt_pkg::ST_OK;
            default:             status_ff <= stt_pkg::ST_OK;
         endcase
      end

      if (state_ff == stt_pkg::S_SCAN) begin
         if (mode_ff == stt_pkg::MODE_TICK) begin
            fire_ff  <= due;
            keep_ff  <= !due || rep_ff[0];
            newlr_ff <= due ? now_ff : lr_ff[0];
         end else begin
            fire_ff  <= 1'b0;
            keep_ff  <= !(id_ff[0] == tid_ff && !found_ff);
            newlr_ff <= lr_ff[0];
         end
      end

      if (state_ff == stt_pkg::S_DIV && div_rsp.done) begin
         newlr_ff <= now_ff - div_rsp.rem;
      end

      if (step_go) begin
         left_ff <= left_ff - 1'b1;
         if (fire_ff) begin
            pend_id_ff <= id_ff[0];
         end
         if (!keep_ff && mode_ff == stt_pkg::MODE_CANCEL) begin
            found_ff  <= 1'b1;
            status_ff <= stt_pkg::ST_OK;
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (keep_ff && CW'(i) == tail) begin
               id_ff[i]  <= id_ff[0];
               per_ff[i] <= per_ff[0];
               lr_ff[i]  <= newlr_ff;
               rep_ff[i] <= rep_ff[0];
            end else if (i < ENTRIES - 1) begin
               id_ff[i]  <= id_ff[(i+1) % ENTRIES];
               per_ff[i] <= per_ff[(i+1) % ENTRIES];
               lr_ff[i]  <= lr_ff[(i+1) % ENTRIES];
               rep_ff[i] <= rep_ff[(i+1) % ENTRIES];
            end
         end
      end

      if (emit_pend) begin
         rsp_status_ff <= stt_pkg::ST_OK;
         rsp_id_ff     <= pend_id_ff;
         rsp_fired_ff  <= 1'b1;
         rsp_last_ff   <= 1'b0;
      end else if (emit_final) begin
         rsp_last_ff <= 1'b1;
         if (mode_ff == stt_pkg::MODE_TICK && pend_ff) begin
            rsp_status_ff <= stt_pkg::ST_OK;
            rsp_id_ff     <= pend_id_ff;
            rsp_fired_ff  <= 1'b1;
         end else begin
            rsp_status_ff <= status_ff;
            rsp_id_ff     <= '0;
            rsp_fired_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
